// ----- src/pqd_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants shared by the pilot QPSK demapper files.
package pqd_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int SYM_W         = 2;
  localparam int WORD_W        = 16;
  localparam int SYMS_PER_WORD = WORD_W / SYM_W;
  localparam int SLOT_W        = $clog2(SYMS_PER_WORD);
  localparam int CFG_IDX_W     = 1;
  localparam int PROD1_W       = 2 * SAMPLE_W;
  localparam int SUM1_W        = PROD1_W + 1;
  localparam int PROD2_W       = SUM1_W + SAMPLE_W;
  localparam int SUM2_W        = PROD2_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SYM_W-1:0]           sym_t;
  typedef logic [WORD_W-1:0]          word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_REAL = 1'b0,
    REG_REF_IMAG = 1'b1
  } cfg_reg_t;

  localparam sample_t REF_REAL_RESET = 16'sh7FFF;
  localparam sample_t REF_IMAG_RESET = 16'sh0000;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SYMS_PER_WORD - 1);

endpackage

// ----- src/pqd_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces: input bin pairs, packed output words, register writes.
interface pqd_in_if import pqd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t pilot_re;
  sample_t pilot_im;
  sample_t data_re;
  sample_t data_im;
  modport source (output valid, pilot_re, pilot_im, data_re, data_im, input ready);
  modport sink (input valid, pilot_re, pilot_im, data_re, data_im, output ready);
endinterface

interface pqd_out_if import pqd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t packed_word;
  logic  last_in_symbol;
  modport source (output valid, packed_word, last_in_symbol, input ready);
  modport sink (input valid, packed_word, last_in_symbol, output ready);
endinterface

interface pqd_cfg_if import pqd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  sample_t              data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/pqd_front.sv -----
`timescale 1ns / 1ps
// Front end: reference registers, quadrant decision for one bin pair at a time.
module pqd_front import pqd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  pqd_in_if.sink  samples,
  pqd_cfg_if.sink cfg,
  output logic  sym_valid,
  output sym_t  sym,
  input  logic  sym_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_SUM1,
    S_MUL2,
    S_PUSH
  } state_t;

  state_t  state;
  sample_t ref_re;
  sample_t ref_im;
  sample_t pr;
  sample_t pi;
  sample_t dr;
  sample_t di;
  logic signed [PROD1_W-1:0] p_a;
  logic signed [PROD1_W-1:0] p_b;
  logic signed [PROD1_W-1:0] p_c;
  logic signed [PROD1_W-1:0] p_d;
  logic signed [SUM1_W-1:0]  tr;
  logic signed [SUM1_W-1:0]  ti;
  logic signed [PROD2_W-1:0] q_a;
  logic signed [PROD2_W-1:0] q_b;
  logic signed [PROD2_W-1:0] q_c;
  logic signed [PROD2_W-1:0] q_d;
  logic [SUM2_W-1:0] qr;
  logic [SUM2_W-1:0] qi;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_re <= REF_REAL_RESET;
      ref_im <= REF_IMAG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_REF_REAL: ref_re <= cfg.data;
        REG_REF_IMAG: ref_im <= cfg.data;
        default: ;
      endcase
    end
  end

  assign samples.ready = (state == S_IDLE);

  // zero counts as negative
  assign qr = {q_a[PROD2_W-1], q_a} + {q_b[PROD2_W-1], q_b};
  assign qi = {q_c[PROD2_W-1], q_c} - {q_d[PROD2_W-1], q_d};
  assign sym = {qr[SUM2_W-1] | (qr == '0), qi[SUM2_W-1] | (qi == '0)};
  assign sym_valid = (state == S_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            pr    <= samples.pilot_re;
            pi    <= samples.pilot_im;
            dr    <= samples.data_re;
            di    <= samples.data_im;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p_a   <= dr * ref_re;
          p_b   <= di * ref_im;
          p_c   <= dr * ref_im;
          p_d   <= di * ref_re;
          state <= S_SUM1;
        end
        S_SUM1: begin
          tr    <= {p_a[PROD1_W-1], p_a} - {p_b[PROD1_W-1], p_b};
          ti    <= {p_c[PROD1_W-1], p_c} + {p_d[PROD1_W-1], p_d};
          state <= S_MUL2;
        end
        S_MUL2: begin
          q_a   <= tr * pr;
          q_b   <= ti * pi;
          q_c   <= ti * pr;
          q_d   <= tr * pi;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (sym_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/pqd_fifo.sv -----
`timescale 1ns / 1ps
// Short symbol queue between the front end and the packer.
module pqd_fifo import pqd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  sym_t push_sym,
  output logic push_ready,
  output logic pop_valid,
  output sym_t pop_sym,
  input  logic pop_ready
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  sym_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_sym    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/pqd_back.sv -----
`timescale 1ns / 1ps
// Back end: pack symbols into words, track pair position, hold the output word.
module pqd_back import pqd_pkg::*; #(
  parameter int FFT_SIZE = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic sym_valid,
  input  sym_t sym,
  output logic sym_ready,
  pqd_out_if.source words
);

  localparam int PAIRS  = FFT_SIZE / 2;
  localparam int PAIR_W = $clog2(PAIRS);

  word_t             pack_shift;
  logic [SLOT_W-1:0] slot_count;
  logic [PAIR_W-1:0] pair_count;
  word_t             pack_shift_next;
  logic              take;
  logic              last_pair;
  logic              full_word;

  assign full_word       = (slot_count == LAST_SLOT);
  assign sym_ready       = !(full_word && words.valid && !words.ready);
  assign take            = sym_valid && sym_ready;
  assign last_pair       = (pair_count == PAIR_W'(PAIRS - 1));
  assign pack_shift_next = {pack_shift[WORD_W-SYM_W-1:0], sym};

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_shift  <= '0;
      slot_count  <= '0;
      pair_count  <= '0;
      words.valid <= 1'b0;
    end else begin
      if (take && full_word) begin
        words.valid          <= 1'b1;
        words.packed_word    <= pack_shift_next;
        words.last_in_symbol <= last_pair;
      end else if (words.ready) begin
        words.valid <= 1'b0;
      end
      if (take) begin
        if (last_pair || full_word) begin
          pack_shift <= '0;
          slot_count <= '0;
        end else begin
          pack_shift <= pack_shift_next;
          slot_count <= slot_count + 1'b1;
        end
        if (last_pair) begin
          pair_count <= '0;
        end else begin
          pair_count <= pair_count + 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/pilot_qpsk_demapper.sv -----
`timescale 1ns / 1ps
// Pilot-aided QPSK demapper top level.
// The front end sequencer takes one bin pair at a time: capture, two multiply steps, one
// add step, then a push into the symbol queue that waits while the queue is full. A word
// is registered at the output when its eighth symbol is taken from the queue.
// Reset (synchronous, active high) restores the reference to 32767 + 0j and
// clears the queue, the packer, the pair count and the output valid.
module pilot_qpsk_demapper import pqd_pkg::*; #(
  parameter int FFT_SIZE = 64
) (
  input  logic clk,
  input  logic rst,
  pqd_in_if.sink    samples,
  pqd_cfg_if.sink   cfg,
  pqd_out_if.source words
);

  logic front_valid;
  sym_t front_sym;
  logic front_ready;
  logic back_valid;
  sym_t back_sym;
  logic back_ready;

  pqd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg       (cfg),
    .sym_valid (front_valid),
    .sym       (front_sym),
    .sym_ready (front_ready)
  );

  pqd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_sym   (front_sym),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_sym    (back_sym),
    .pop_ready  (back_ready)
  );

  pqd_back #(
    .FFT_SIZE (FFT_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (back_valid),
    .sym       (back_sym),
    .sym_ready (back_ready),
    .words     (words)
  );

endmodule

// ----- src/pqd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the demapper, bound to the top level.
module pqd_checker import pqd_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t out_word,
  input logic  out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_word) && $stable(out_last))
    else $error("output item changed while stalled");

  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_in_spacing: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while front end busy");

endmodule

bind pilot_qpsk_demapper pqd_checker u_pqd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (words.valid),
  .out_ready (words.ready),
  .out_word  (words.packed_word),
  .out_last  (words.last_in_symbol)
);
